[sv/rcs_pkg.sv]
`timescale 1ns / 1ps
package rcs_pkg;

   localparam int PIX_W     = 8;
   localparam int NUM_W     = 2 * PIX_W;
   localparam int LANES     = 3;
   localparam int QUOT_BITS = PIX_W;
   localparam int CNT_W     = $clog2(QUOT_BITS);

   localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;
   localparam logic [PIX_W-1:0] MIN_RESET  = 8'd255;
   localparam logic [PIX_W-1:0] MAX_RESET  = 8'd0;

   // channel order inside a lane array
   localparam int CH_BLUE  = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_RED   = 2;

   localparam logic REQ_MEASURE = 1'b0;
   localparam logic REQ_APPLY   = 1'b1;

   typedef struct packed {
      logic             req_type;
      logic             frame_start;
      logic [PIX_W-1:0] blue_in;
      logic [PIX_W-1:0] green_in;
      logic [PIX_W-1:0] red_in;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] blue_out;
      logic [PIX_W-1:0] green_out;
      logic [PIX_W-1:0] red_out;
   } rsp_type;

   // one division job for one channel: num = (clamped x - min) * 255, den = max - min
   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [PIX_W-1:0] den;
   } lane_type;

   typedef lane_type [LANES-1:0] job_type;

endpackage

[sv/rcs_front.sv]
`timescale 1ns / 1ps
module rcs_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  rcs_pkg::req_type req_data,
   output logic            push,
   output rcs_pkg::job_type job,
   input  logic            queue_full
);

   localparam int W = rcs_pkg::PIX_W;

   logic [W-1:0] lo_ff [rcs_pkg::LANES];
   logic [W-1:0] lo_in [rcs_pkg::LANES];
   logic [W-1:0] hi_ff [rcs_pkg::LANES];
   logic [W-1:0] hi_in [rcs_pkg::LANES];
   logic [W-1:0] px    [rcs_pkg::LANES];
   logic         accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign push      = accept && (req_data.req_type == rcs_pkg::REQ_APPLY);

   assign px[rcs_pkg::CH_BLUE]  = req_data.blue_in;
   assign px[rcs_pkg::CH_GREEN] = req_data.green_in;
   assign px[rcs_pkg::CH_RED]   = req_data.red_in;

   always_comb begin
      logic [W-1:0] base_lo;
      logic [W-1:0] base_hi;
      logic [W-1:0] v;
      logic [W-1:0] d;
      for (int i = 0; i < rcs_pkg::LANES; i++) begin
         // track: frame start restarts from the reset values
         base_lo  = req_data.frame_start ? rcs_pkg::MIN_RESET : lo_ff[i];
         base_hi  = req_data.frame_start ? rcs_pkg::MAX_RESET : hi_ff[i];
         lo_in[i] = (px[i] < base_lo) ? px[i] : base_lo;
         hi_in[i] = (px[i] > base_hi) ? px[i] : base_hi;

         // apply: clamp, offset, scale by 255 as (d << 8) - d
         v = (px[i] < lo_ff[i]) ? lo_ff[i] : ((px[i] > hi_ff[i]) ? hi_ff[i] : px[i]);
         d = v - lo_ff[i];
         if (hi_ff[i] > lo_ff[i]) begin
            job[i].num = {d, {W{1'b0}}} - {{W{1'b0}}, d};
            job[i].den = hi_ff[i] - lo_ff[i];
         end else begin
            job[i].num = '0;
            job[i].den = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rcs_pkg::LANES; i++) begin
            lo_ff[i] <= rcs_pkg::MIN_RESET;
            hi_ff[i] <= rcs_pkg::MAX_RESET;
         end
      end else if (accept && (req_data.req_type == rcs_pkg::REQ_MEASURE)) begin
         for (int i = 0; i < rcs_pkg::LANES; i++) begin
            lo_ff[i] <= lo_in[i];
            hi_ff[i] <= hi_in[i];
         end
      end
   end

endmodule

[sv/rcs_queue.sv]
`timescale 1ns / 1ps
module rcs_queue #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rcs_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output rcs_pkg::job_type pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rcs_pkg::job_type mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff;
   logic [PW-1:0]    rd_ptr_in;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[sv/rcs_back.sv]
`timescale 1ns / 1ps
module rcs_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_empty,
   input  rcs_pkg::job_type job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rcs_pkg::rsp_type rsp_data
);

   localparam int W = rcs_pkg::PIX_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DIV  = 1'b1;

   logic                     state_ff;
   logic                     state_in;
   logic [rcs_pkg::CNT_W-1:0] cnt_ff;
   logic [rcs_pkg::CNT_W-1:0] cnt_in;
   logic [W-1:0]             rem_ff  [rcs_pkg::LANES];
   logic [W-1:0]             rem_in  [rcs_pkg::LANES];
   logic [W-1:0]             low_ff  [rcs_pkg::LANES];
   logic [W-1:0]             low_in  [rcs_pkg::LANES];
   logic [W-1:0]             den_ff  [rcs_pkg::LANES];
   logic [W-1:0]             quot    [rcs_pkg::LANES];
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   rcs_pkg::rsp_type         rsp_data_ff;
   logic                     out_free;
   logic                     last;
   logic                     step;
   logic                     finish;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign last     = (cnt_ff == rcs_pkg::CNT_W'(rcs_pkg::QUOT_BITS - 1));
   assign pop      = (state_ff == ST_IDLE) && !job_empty;
   // hold the last step until the output register is free
   assign step     = (state_ff == ST_DIV) && (!last || out_free);
   assign finish   = step && last;

   // one restoring quotient bit per lane per cycle while dividing; the last step waits for a free output register
   always_comb begin
      logic [W:0] t;
      logic       ge;
      for (int i = 0; i < rcs_pkg::LANES; i++) begin
         t         = {rem_ff[i], low_ff[i][W-1]};
         ge        = (t >= {1'b0, den_ff[i]});
         rem_in[i] = ge ? W'(t - {1'b0, den_ff[i]}) : t[W-1:0];
         low_in[i] = {low_ff[i][W-2:0], ge};
         quot[i]   = (den_ff[i] == '0) ? '0 : low_in[i];
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               state_in = ST_DIV;
               cnt_in   = '0;
            end
         end
         ST_DIV: begin
            if (step) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (finish) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         for (int i = 0; i < rcs_pkg::LANES; i++) begin
            rem_ff[i] <= job[i].num[rcs_pkg::NUM_W-1:W];
            low_ff[i] <= job[i].num[W-1:0];
            den_ff[i] <= job[i].den;
         end
      end else if (step) begin
         for (int i = 0; i < rcs_pkg::LANES; i++) begin
            rem_ff[i] <= rem_in[i];
            low_ff[i] <= low_in[i];
         end
      end
      if (finish) begin
         rsp_data_ff.blue_out  <= quot[rcs_pkg::CH_BLUE];
         rsp_data_ff.green_out <= quot[rcs_pkg::CH_GREEN];
         rsp_data_ff.red_out   <= quot[rcs_pkg::CH_RED];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[sv/rgb_contrast_stretch.sv]
`timescale 1ns / 1ps
// Per-channel min-max contrast stretch for BGR pixels, two passes per frame.
// Input channel req_valid/req_ready/req_data carries items; req_type selects
// measure (update running min/max of blue, green, red, no result; frame_start
// restarts the trackers first) or apply (one stretched pixel on rsp_*).
// Each apply channel gives (clamp(x) - min) * 255 / (max - min), 0 when the
// range is empty or zero.
// Measure items are taken one per cycle while the job queue has room.
// An apply item is queued in the cycle it is accepted; the back end pops it
// when idle and runs three 8-step restoring dividers in parallel, one
// quotient bit per cycle except that the last step waits for a free output
// register, and it takes the next queued item only after the result is
// registered for rsp_valid.
// Reset (synchronous, active high) sets min to 255 and max to 0 in every
// channel and empties the queue and the output register.
// When the receiver stalls, the result waits in the output register, the
// dividers hold their last step, and the queue fills; req_ready drops only
// when the queue is full.
module rgb_contrast_stretch #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rcs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rcs_pkg::rsp_type rsp_data
);

   // front to queue
   logic             push;
   rcs_pkg::job_type push_job;
   logic             queue_full;

   // queue to back
   logic             pop;
   rcs_pkg::job_type pop_job;
   logic             queue_empty;

   // classify items, track min/max, build divider jobs
   rcs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push       (push),
      .job        (push_job),
      .queue_full (queue_full)
   );

   // decouple the front from the dividers
   rcs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_job),
      .empty     (queue_empty)
   );

   // divide and register the result pixel
   rcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (queue_empty),
      .job       (pop_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[sv/rcs_checker.sv]
`timescale 1ns / 1ps
module rcs_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input rcs_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rcs_pkg::rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   // reset leaves no result pending and an empty queue
   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("result or back-pressure right after reset");

   // only queued apply items can fill the queue
   a_full_cause: assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |->
         $past(req_valid && req_ready && (req_data.req_type == rcs_pkg::REQ_APPLY)))
      else $error("input stalled without an apply item entering");

endmodule

bind rgb_contrast_stretch rcs_checker u_rcs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
